@@ rtl/core/srspm_pkg.sv @@
// shared types and constants for the sprite rotate/scale pixel mapper
// no dependencies; imported by every module of the block
package srspm_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_COS_COEFF  = 3'd0;
	localparam logic [2:0] REG_SIN_COEFF  = 3'd1;
	localparam logic [2:0] REG_PIVOT_X    = 3'd2;
	localparam logic [2:0] REG_PIVOT_Y    = 3'd3;
	localparam logic [2:0] REG_CENTER_X   = 3'd4;
	localparam logic [2:0] REG_CENTER_Y   = 3'd5;
	localparam logic [2:0] REG_TRANSP     = 3'd6;
	localparam logic [2:0] REG_STEP_SIZE  = 3'd7;

	localparam int COEFF_W  = 16;
	localparam int PIVOT_W  = 11;
	localparam int CENTER_W = 13;
	localparam int COLOR_W  = 8;
	localparam int COORD_W  = 8;
	localparam int STEP_W   = 3;
	localparam int DEST_W   = 16;
	localparam int CFG_W    = 16;
	localparam int IDX_W    = 3;

	// offset from pivot: 8-bit unsigned minus 11-bit signed
	localparam int LX_W   = 12;
	localparam int PROD_W = LX_W + COEFF_W;
	localparam int SUM_W  = PROD_W + 1;

	localparam int QUEUE_DEPTH = 2;

	localparam logic signed [DEST_W-1:0] DEST_MAX = 16'sh7fff;
	localparam logic signed [DEST_W-1:0] DEST_MIN = 16'sh8000;

	typedef struct packed {
		logic [COEFF_W-1:0]  cos_coeff;
		logic [COEFF_W-1:0]  sin_coeff;
		logic [PIVOT_W-1:0]  pivot_x;
		logic [PIVOT_W-1:0]  pivot_y;
		logic [CENTER_W-1:0] center_x;
		logic [CENTER_W-1:0] center_y;
		logic [COLOR_W-1:0]  transparent_color;
		logic [STEP_W-1:0]   step_size;
	} srspm_cfg_t;

	// one kept pixel, offsets relative to the pivot
	typedef struct packed {
		logic [LX_W-1:0]    lx;
		logic [LX_W-1:0]    ly;
		logic [COLOR_W-1:0] color;
	} srspm_item_t;

endpackage

@@ rtl/core/srspm_front.sv @@
// front end: accepts source pixels, drops off-grid, out-of-sprite and transparent ones
// depends on srspm_pkg; feeds srspm_queue
module srspm_front #(
	parameter int SPRITE_DIM = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  srspm_pkg::srspm_cfg_t           cfg,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [srspm_pkg::COORD_W-1:0]   src_x,
	input  logic [srspm_pkg::COORD_W-1:0]   src_y,
	input  logic [srspm_pkg::COLOR_W-1:0]   pixel_color,
	output logic                            push_valid,
	input  logic                            push_ready,
	output srspm_pkg::srspm_item_t          push_item
);
	import srspm_pkg::*;

	logic        valid_s1;
	srspm_item_t item_s1;
	logic        out_of_range;
	logic        on_grid;
	logic        keep;

	// base-4 digit sum keeps the residue mod 3
	function automatic logic is_mult3(input logic [COORD_W-1:0] v);
		logic [3:0] s;
		s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
		return (s == 4'd0) || (s == 4'd3) || (s == 4'd6) || (s == 4'd9) || (s == 4'd12);
	endfunction

	always_comb begin
		out_of_range = (32'(src_x) >= 32'(SPRITE_DIM)) || (32'(src_y) >= 32'(SPRITE_DIM));
		case (cfg.step_size) inside
			3'd0, 3'd1: on_grid = 1'b1;
			3'd2:       on_grid = !src_x[0] && !src_y[0];
			3'd3:       on_grid = is_mult3(src_x) && is_mult3(src_y);
			default:    on_grid = (src_x[1:0] == 2'd0) && (src_y[1:0] == 2'd0);
		endcase
		keep = !out_of_range && on_grid && (pixel_color != cfg.transparent_color);
	end

	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.lx    <= LX_W'(src_x) - LX_W'($signed(cfg.pivot_x));
			item_s1.ly    <= LX_W'(src_y) - LX_W'($signed(cfg.pivot_y));
			item_s1.color <= pixel_color;
		end
	end

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(push_valid && !push_ready) |=> (push_valid && $stable(item_s1)))
		else $error("front word changed while stalled");

	a_drop_transparent: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (pixel_color == cfg.transparent_color)) |=> !valid_s1)
		else $error("transparent pixel kept");

	a_drop_range: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && out_of_range) |=> !valid_s1)
		else $error("pixel outside sprite kept");

endmodule

@@ rtl/core/srspm_queue.sv @@
// short fifo between the classifying front end and the arithmetic back end
// depends on srspm_pkg for the word type and depth
module srspm_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push_valid,
	output logic                    push_ready,
	input  srspm_pkg::srspm_item_t  push_item,
	output logic                    pop_valid,
	input  logic                    pop_ready,
	output srspm_pkg::srspm_item_t  pop_item
);
	import srspm_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	srspm_item_t            mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]       wr_ptr_q;
	logic [PTR_W-1:0]       rd_ptr_q;
	logic [CNT_W-1:0]       count_q;
	logic                   push;
	logic                   pop;

	assign push_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count past depth");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("queue count lost a push");

	a_head_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(pop_valid && !pop_ready) |=> (pop_valid && $stable(pop_item)))
		else $error("queue head changed without pop");

endmodule

@@ rtl/core/srspm_back.sv @@
// back end: rotate/scale multiply, round half away from zero, add center, saturate
// depends on srspm_pkg; drains srspm_queue and holds the output register
module srspm_back #(
	parameter int COEFF_FRAC_BITS = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  srspm_pkg::srspm_cfg_t               cfg,
	input  logic                                pop_valid,
	output logic                                pop_ready,
	input  srspm_pkg::srspm_item_t              pop_item,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [srspm_pkg::DEST_W-1:0] dest_x,
	output logic signed [srspm_pkg::DEST_W-1:0] dest_y,
	output logic [srspm_pkg::COLOR_W-1:0]       dot_color
);
	import srspm_pkg::*;

	localparam logic signed [SUM_W-1:0] HALF = SUM_W'(64'd1 << (COEFF_FRAC_BITS - 1));
	localparam int OUT_W = SUM_W + 1;

	logic                       en;
	logic                       valid_s1, valid_s2, valid_s3, out_valid_q;
	logic signed [PROD_W-1:0]   xc_s1, ys_s1, xs_s1, yc_s1;
	logic signed [SUM_W-1:0]    rx_s2, ry_s2;
	logic signed [SUM_W-1:0]    rx_s3, ry_s3;
	logic [COLOR_W-1:0]         color_s1, color_s2, color_s3;
	logic signed [DEST_W-1:0]   dest_x_q, dest_y_q;
	logic [COLOR_W-1:0]         color_q;
	logic signed [OUT_W-1:0]    sum_x, sum_y;

	// whole pipeline moves together unless the output word is stuck
	assign en        = !out_valid_q || out_ready;
	assign pop_ready = en;
	assign out_valid = out_valid_q;
	assign dest_x    = dest_x_q;
	assign dest_y    = dest_y_q;
	assign dot_color = color_q;

	function automatic logic signed [SUM_W-1:0] round_q(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] biased;
		// negative ties go down: add half minus one before the floor shift
		biased = v + (v[SUM_W-1] ? (HALF - SUM_W'(1)) : HALF);
		return biased >>> COEFF_FRAC_BITS;
	endfunction

	function automatic logic signed [DEST_W-1:0] sat(input logic signed [OUT_W-1:0] v);
		if (v > OUT_W'(DEST_MAX)) begin
			return DEST_MAX;
		end else if (v < OUT_W'(DEST_MIN)) begin
			return DEST_MIN;
		end
		return v[DEST_W-1:0];
	endfunction

	always_comb begin
		sum_x = OUT_W'(rx_s3) + OUT_W'($signed(cfg.center_x));
		sum_y = OUT_W'(ry_s3) + OUT_W'($signed(cfg.center_y));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= pop_valid;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xc_s1    <= PROD_W'($signed(pop_item.lx)) * PROD_W'($signed(cfg.cos_coeff));
			ys_s1    <= PROD_W'($signed(pop_item.ly)) * PROD_W'($signed(cfg.sin_coeff));
			xs_s1    <= PROD_W'($signed(pop_item.lx)) * PROD_W'($signed(cfg.sin_coeff));
			yc_s1    <= PROD_W'($signed(pop_item.ly)) * PROD_W'($signed(cfg.cos_coeff));
			color_s1 <= pop_item.color;

			rx_s2    <= SUM_W'(xc_s1) - SUM_W'(ys_s1);
			ry_s2    <= SUM_W'(xs_s1) + SUM_W'(yc_s1);
			color_s2 <= color_s1;

			rx_s3    <= round_q(rx_s2);
			ry_s3    <= round_q(ry_s2);
			color_s3 <= color_s2;

			if (valid_s3) begin
				dest_x_q <= sat(sum_x);
				dest_y_q <= sat(sum_y);
				color_q  <= color_s3;
			end
		end
	end

	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> ($stable(valid_s1) && $stable(valid_s2) && $stable(valid_s3)))
		else $error("pipeline moved during stall");

	a_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && en) |=> out_valid)
		else $error("word lost entering output register");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable(dest_x_q) && $stable(dest_y_q))
		else $error("output word changed while stalled");

endmodule

@@ rtl/core/sprite_rotate_scale_pixel_mapper.sv @@
// Sprite rotate/scale pixel mapper: one source pixel per clock is accepted while out_ready
// holds and, unless it is off the subsampling grid, outside the sprite or of the transparent
// color, mapped to a destination position (pivot-relative rotate/scale in Q3.12, rounded
// half away from zero, plus center, saturated to 16 bits signed). Sustained rate is one
// pixel per clock in both directions while out_ready holds. An input word passes the front
// register, two-entry queue, multiply, add, round and center/saturate output register.
// Configuration writes take effect at once and belong only while no pixel is in flight.
// depends on srspm_pkg, srspm_front, srspm_queue, srspm_back
module sprite_rotate_scale_pixel_mapper #(
	parameter int SPRITE_DIM      = 256,
	parameter int COEFF_FRAC_BITS = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [srspm_pkg::IDX_W-1:0]         cfg_index,
	input  logic [srspm_pkg::CFG_W-1:0]         cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [srspm_pkg::COORD_W-1:0]       src_x,
	input  logic [srspm_pkg::COORD_W-1:0]       src_y,
	input  logic [srspm_pkg::COLOR_W-1:0]       pixel_color,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [srspm_pkg::DEST_W-1:0] dest_x,
	output logic signed [srspm_pkg::DEST_W-1:0] dest_y,
	output logic [srspm_pkg::COLOR_W-1:0]       dot_color
);
	import srspm_pkg::*;

	srspm_cfg_t  cfg_q;
	logic        push_valid, push_ready;
	srspm_item_t push_item;
	logic        pop_valid, pop_ready;
	srspm_item_t pop_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cos_coeff         <= COEFF_W'(64'd1 << COEFF_FRAC_BITS);
			cfg_q.sin_coeff         <= '0;
			cfg_q.pivot_x           <= '0;
			cfg_q.pivot_y           <= '0;
			cfg_q.center_x          <= '0;
			cfg_q.center_y          <= '0;
			cfg_q.transparent_color <= '0;
			cfg_q.step_size         <= STEP_W'(1);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_COS_COEFF: cfg_q.cos_coeff         <= cfg_data;
				REG_SIN_COEFF: cfg_q.sin_coeff         <= cfg_data;
				REG_PIVOT_X:   cfg_q.pivot_x           <= cfg_data[PIVOT_W-1:0];
				REG_PIVOT_Y:   cfg_q.pivot_y           <= cfg_data[PIVOT_W-1:0];
				REG_CENTER_X:  cfg_q.center_x          <= cfg_data[CENTER_W-1:0];
				REG_CENTER_Y:  cfg_q.center_y          <= cfg_data[CENTER_W-1:0];
				REG_TRANSP:    cfg_q.transparent_color <= cfg_data[COLOR_W-1:0];
				REG_STEP_SIZE: cfg_q.step_size         <= cfg_data[STEP_W-1:0];
				default:       cfg_q                   <= cfg_q;
			endcase
		end
	end

	srspm_front #(
		.SPRITE_DIM(SPRITE_DIM)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.src_x      (src_x),
		.src_y      (src_y),
		.pixel_color(pixel_color),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	srspm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item (push_item),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item)
	);

	srspm_back #(
		.COEFF_FRAC_BITS(COEFF_FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_item (pop_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.dest_x   (dest_x),
		.dest_y   (dest_y),
		.dot_color(dot_color)
	);

endmodule

@@ tb/sv/tb_sprite_rotate_scale_pixel_mapper.sv @@
// self-checking bench for the sprite rotate/scale pixel mapper: directed and random pixels,
// an in-bench predictor of the mapped dot, and random idling on both handshakes
// depends on srspm_pkg and sprite_rotate_scale_pixel_mapper
`timescale 1ns / 1ps

module tb_sprite_rotate_scale_pixel_mapper;
	import srspm_pkg::*;

	localparam int COEFF_FRAC = 12;
	localparam int DRAIN      = 12;

	typedef struct {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COLOR_W-1:0] color;
	} pixel_t;

	typedef struct {
		logic signed [DEST_W-1:0] x;
		logic signed [DEST_W-1:0] y;
		logic [COLOR_W-1:0]       color;
	} dot_t;

	typedef struct {
		logic signed [COEFF_W-1:0]  cos_k;
		logic signed [COEFF_W-1:0]  sin_k;
		logic signed [PIVOT_W-1:0]  piv_x;
		logic signed [PIVOT_W-1:0]  piv_y;
		logic signed [CENTER_W-1:0] ctr_x;
		logic signed [CENTER_W-1:0] ctr_y;
		logic [COLOR_W-1:0]         transp;
		logic [STEP_W-1:0]          step;
	} xform_t;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_wr_en;
	logic [IDX_W-1:0]           cfg_index;
	logic [CFG_W-1:0]           cfg_data;
	logic                       in_valid;
	logic                       in_ready;
	logic [COORD_W-1:0]         src_x;
	logic [COORD_W-1:0]         src_y;
	logic [COLOR_W-1:0]         pixel_color;
	logic                       out_valid;
	logic                       out_ready;
	logic signed [DEST_W-1:0]   dest_x;
	logic signed [DEST_W-1:0]   dest_y;
	logic [COLOR_W-1:0]         dot_color;

	xform_t xform;
	pixel_t pixel_q[$];
	dot_t   expected_dots[$];
	dot_t   got_dot;
	pixel_t next_px;
	logic   px_taken = 1'b0;
	logic   calm;
	int     fail_count = 0;

	sprite_rotate_scale_pixel_mapper #(
		.SPRITE_DIM(256),
		.COEFF_FRAC_BITS(COEFF_FRAC)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.src_x(src_x),
		.src_y(src_y),
		.pixel_color(pixel_color),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.dest_x(dest_x),
		.dest_y(dest_y),
		.dot_color(dot_color)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic bit idle_now();
		return !calm && ($urandom_range(0, 99) < 24);
	endfunction

	// step of zero acts as one, anything above four as four
	function automatic int eff_step();
		int st;
		st = int'(xform.step);
		if (st < 1) st = 1;
		if (st > 4) st = 4;
		return st;
	endfunction

	function automatic longint round_half_away(input longint v);
		if (v < 0)
			return -(((-v) + (longint'(1) << (COEFF_FRAC - 1))) >>> COEFF_FRAC);
		return (v + (longint'(1) << (COEFF_FRAC - 1))) >>> COEFF_FRAC;
	endfunction

	function automatic logic signed [DEST_W-1:0] clamp_dest(input longint v);
		if (v > 32767) return DEST_MAX;
		if (v < -32768) return DEST_MIN;
		return v[DEST_W-1:0];
	endfunction

	function automatic void map_pixel(input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
			input logic [COLOR_W-1:0] col);
		dot_t   d;
		int     st;
		longint lx, ly, rx, ry;
		st = eff_step();
		if (st > 1 && ((int'(sx) % st) != 0 || (int'(sy) % st) != 0))
			return;
		if (col == xform.transp)
			return;
		lx = longint'(sx) - longint'(xform.piv_x);
		ly = longint'(sy) - longint'(xform.piv_y);
		rx = lx * longint'(xform.cos_k) - ly * longint'(xform.sin_k);
		ry = lx * longint'(xform.sin_k) + ly * longint'(xform.cos_k);
		d.x = clamp_dest(longint'(xform.ctr_x) + round_half_away(rx));
		d.y = clamp_dest(longint'(xform.ctr_y) + round_half_away(ry));
		d.color = col;
		expected_dots.push_back(d);
	endfunction

	// input side: predict on accept, present the next word at the falling edge
	always @(posedge clk) begin
		px_taken <= in_valid && in_ready;
		if (arst_n && in_valid && in_ready)
			map_pixel(src_x, src_y, pixel_color);
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || px_taken) begin
			if (pixel_q.size() != 0 && !idle_now()) begin
				next_px = pixel_q.pop_front();
				in_valid <= 1'b1;
				src_x <= next_px.x;
				src_y <= next_px.y;
				pixel_color <= next_px.color;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output side
	always @(negedge clk) begin
		out_ready <= arst_n && !idle_now();
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_dots.size() == 0) begin
				$error("unexpected word: dest_x %0d dest_y %0d dot_color %0d",
					dest_x, dest_y, dot_color);
				fail_count++;
			end else begin
				got_dot = expected_dots.pop_front();
				if (dest_x !== got_dot.x) begin
					$error("dest_x expected %0d got %0d", got_dot.x, dest_x);
					fail_count++;
				end
				if (dest_y !== got_dot.y) begin
					$error("dest_y expected %0d got %0d", got_dot.y, dest_y);
					fail_count++;
				end
				if (dot_color !== got_dot.color) begin
					$error("dot_color expected %0d got %0d", got_dot.color, dot_color);
					fail_count++;
				end
			end
		end
	end

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_COS_COEFF: xform.cos_k = data[COEFF_W-1:0];
			REG_SIN_COEFF: xform.sin_k = data[COEFF_W-1:0];
			REG_PIVOT_X:   xform.piv_x = data[PIVOT_W-1:0];
			REG_PIVOT_Y:   xform.piv_y = data[PIVOT_W-1:0];
			REG_CENTER_X:  xform.ctr_x = data[CENTER_W-1:0];
			REG_CENTER_Y:  xform.ctr_y = data[CENTER_W-1:0];
			REG_TRANSP:    xform.transp = data[COLOR_W-1:0];
			REG_STEP_SIZE: xform.step = data[STEP_W-1:0];
			default: ;
		endcase
	endtask

	// unused upper data bits carry junk, the block must ignore them
	task automatic set_xform(input logic [COEFF_W-1:0] c, input logic [COEFF_W-1:0] s,
			input logic [PIVOT_W-1:0] px, input logic [PIVOT_W-1:0] py,
			input logic [CENTER_W-1:0] cx, input logic [CENTER_W-1:0] cy,
			input logic [COLOR_W-1:0] tc, input logic [STEP_W-1:0] st);
		logic [CFG_W-1:0] junk;
		junk = CFG_W'($urandom());
		write_reg(REG_COS_COEFF, c);
		write_reg(REG_SIN_COEFF, s);
		write_reg(REG_PIVOT_X, {junk[CFG_W-1:PIVOT_W], px});
		write_reg(REG_PIVOT_Y, {~junk[CFG_W-1:PIVOT_W], py});
		write_reg(REG_CENTER_X, {junk[CFG_W-1:CENTER_W], cx});
		write_reg(REG_CENTER_Y, {~junk[CFG_W-1:CENTER_W], cy});
		write_reg(REG_TRANSP, {junk[CFG_W-1:COLOR_W], tc});
		write_reg(REG_STEP_SIZE, {junk[CFG_W-1:STEP_W], st});
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic push_px(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
			input logic [COLOR_W-1:0] c);
		pixel_t p;
		p.x = x;
		p.y = y;
		p.color = c;
		pixel_q.push_back(p);
	endtask

	// wait for every dot, then for dropped pixels still in the pipe
	task automatic settle();
		do @(negedge clk);
		while (pixel_q.size() != 0 || in_valid || expected_dots.size() != 0);
		repeat (DRAIN) @(negedge clk);
	endtask

	task automatic random_phase(input int n);
		logic [COEFF_W-1:0]  c, s;
		logic [PIVOT_W-1:0]  px, py;
		logic [CENTER_W-1:0] cx, cy;
		logic [COLOR_W-1:0]  tc;
		logic [STEP_W-1:0]   st;
		logic [COLOR_W-1:0]  col;
		int                  grid;
		case ($urandom_range(0, 2))
			0: begin
				c = COEFF_W'($urandom());
				s = COEFF_W'($urandom());
			end
			1: begin
				c = COEFF_W'($urandom_range(0, 16384) - 8192);
				s = COEFF_W'($urandom_range(0, 16384) - 8192);
			end
			default: begin
				c = 16'd4096;
				s = 16'd0;
			end
		endcase
		px = PIVOT_W'(($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 255));
		py = PIVOT_W'(($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 255));
		cx = CENTER_W'($urandom());
		cy = CENTER_W'($urandom());
		tc = COLOR_W'($urandom());
		st = ($urandom_range(0, 9) < 5) ? 3'd1 : STEP_W'($urandom_range(0, 7));
		set_xform(c, s, px, py, cx, cy, tc, st);
		grid = eff_step();
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 85) begin
				// on the grid and opaque
				col = COLOR_W'($urandom());
				if (col == tc) col = col + 1'b1;
				push_px(COORD_W'((int'($urandom_range(0, 255)) / grid) * grid),
					COORD_W'((int'($urandom_range(0, 255)) / grid) * grid), col);
			end else begin
				push_px(COORD_W'($urandom()), COORD_W'($urandom()),
					($urandom_range(0, 1) != 0) ? tc : COLOR_W'($urandom()));
			end
		end
		settle();
	endtask

	initial begin
		#4_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		src_x = '0;
		src_y = '0;
		pixel_color = '0;
		out_ready = 1'b0;
		calm = 1'b0;
		xform.cos_k = 16'sd4096;
		xform.sin_k = '0;
		xform.piv_x = '0;
		xform.piv_y = '0;
		xform.ctr_x = '0;
		xform.ctr_y = '0;
		xform.transp = '0;
		xform.step = 3'd1;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// identity after reset, color zero is transparent
		push_px(8'd0, 8'd0, 8'd1);
		push_px(8'd255, 8'd255, 8'd255);
		push_px(8'd0, 8'd0, 8'd0);
		push_px(8'd128, 8'd1, 8'd170);
		settle();

		// coefficient and offset extremes on both axes
		set_xform(16'h7fff, 16'h8000, -11'sd1024, 11'sd1023, 13'sd4095, -13'sd4096,
			8'd255, 3'd1);
		push_px(8'd255, 8'd255, 8'd1);
		push_px(8'd0, 8'd0, 8'd254);
		push_px(8'd255, 8'd0, 8'd127);
		push_px(8'd0, 8'd255, 8'd255);
		settle();

		// opposite extremes, step of zero
		set_xform(16'h8000, 16'h7fff, 11'sd1023, -11'sd1024, -13'sd4096, 13'sd4095,
			8'd0, 3'd0);
		push_px(8'd0, 8'd0, 8'd128);
		push_px(8'd255, 8'd255, 8'd1);
		push_px(8'd3, 8'd7, 8'd0);
		settle();

		// half scale gives exact ties, step above four
		set_xform(16'd2048, -16'sd2048, 11'sd3, 11'sd0, 13'sd0, 13'sd0, 8'd17, 3'd5);
		push_px(8'd0, 8'd0, 8'd9);
		push_px(8'd4, 8'd4, 8'd1);
		push_px(8'd2, 8'd4, 8'd3);
		push_px(8'd4, 8'd8, 8'd17);
		push_px(8'd8, 8'd0, 8'd0);
		settle();

		// step of three
		set_xform(16'd4096, 16'd0, 11'sd0, 11'sd0, 13'sd100, -13'sd100, 8'd0, 3'd3);
		push_px(8'd3, 8'd6, 8'd5);
		push_px(8'd4, 8'd6, 8'd5);
		push_px(8'd255, 8'd252, 8'd200);
		push_px(8'd1, 8'd0, 8'd7);
		settle();

		for (int p = 0; p < 10; p++) begin
			calm = (p == 4);
			random_phase(103);
		end
		calm = 1'b0;

		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
